FILE: rtl/partition_fit_allocator_unit_assert.svh
// assertion macros shared by the allocator rtl
`ifndef PARTITION_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// antecedent implies consequent in the cycle after
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

FILE: rtl/pfa_pkg.sv
// types and codes of the partition fit allocator
package pfa_pkg;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_RESTORE = 2'd1;
   localparam logic [1:0] OP_ALLOC   = 2'd2;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   localparam logic [1:0] STATUS_ACK    = 2'd0;
   localparam logic [1:0] STATUS_PLACED = 2'd1;
   localparam logic [1:0] STATUS_WAIT   = 2'd2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCKS_IN_USE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_POLICY    = 1'd1;

   localparam int INDEX_FIELD_W  = 4;
   localparam int AMOUNT_FIELD_W = 16;

   typedef struct packed {
      logic       clear;
      logic       sample;
      logic [1:0] policy;
   } fit_ctl_type;

endpackage

FILE: rtl/partition_fit_allocator_unit.sv
// top level of the partition fit allocator
//
//  group  direction  beat carries
//  req_   in         tuser opcode, tdata block_index and amount
//  rsp_   out        tuser status, tdata granted, chosen_block, free_before
//  csr_   in         register index and write data
//
// load and unused opcodes go straight to finish; restore sweeps the first N entries and
// allocate sweeps them and then commits, where N is the clamped block count;
// the single read port of each block memory is swept one entry per cycle, so the
// scan length sets the rate.
// reset clears entry valid bits at once; no clearing pass is needed.
// a finished result waits in the output register while the next beat is accepted;
// finish holds while that register is still full and rsp_tready is low.
module partition_fit_allocator_unit #(
   parameter int BLOCKS    = 16,
   parameter int SIZE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // block_index, amount
   input  logic [1:0]                        req_tuser,  // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // granted, chosen_block, free_before
   output logic [1:0]                        rsp_tuser,  // status
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pfa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pfa_pkg::CSR_DATA_W-1:0]    csr_data
);

   `include "partition_fit_allocator_unit_assert.svh"

   localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CNT_W = $clog2(BLOCKS + 1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RESTORE = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_COMMIT  = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   logic [SIZE_BITS-1:0] orig_mem [BLOCKS];
   logic [SIZE_BITS-1:0] free_mem [BLOCKS];
   logic [SIZE_BITS-1:0] orig_rd_ff;
   logic [SIZE_BITS-1:0] free_rd_ff;
   logic [BLOCKS-1:0]    orig_valid_ff, orig_valid_in;
   logic [BLOCKS-1:0]    free_valid_ff, free_valid_in;

   logic [2:0]           state_ff, state_in;
   logic [4:0]           blocks_ff, blocks_in;
   logic [1:0]           policy_ff, policy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     tag_ff, tag_in;
   logic                 pend_ff, pend_in;
   logic [SIZE_BITS-1:0] amt_ff, amt_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_pick_ff, rsp_pick_in;
   logic [15:0]          rsp_before_ff, rsp_before_in;

   logic                 orig_we;
   logic                 free_we;
   logic [IDX_W-1:0]     free_waddr;
   logic [SIZE_BITS-1:0] free_wdata;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     load_addr;
   logic [SIZE_BITS-1:0] req_amount;
   logic [SIZE_BITS-1:0] free_cur;
   logic [SIZE_BITS-1:0] orig_cur;
   logic [CNT_W-1:0]     lim;
   logic                 issue;
   logic                 req_fire;
   logic                 load_ok;
   logic                 out_free;

   pfa_pkg::fit_ctl_type fit_ctl;
   logic                 fit_found;
   logic [IDX_W-1:0]     fit_pick;
   logic [SIZE_BITS-1:0] fit_left;
   logic [SIZE_BITS-1:0] fit_before;

   assign csr_ready  = 1'b1;
   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign lim        = (32'(blocks_ff) > BLOCKS) ? CNT_W'(BLOCKS) : CNT_W'(blocks_ff);
   assign issue      = cnt_ff < lim;
   assign rd_addr    = cnt_ff[IDX_W-1:0];
   assign load_addr  = IDX_W'(req_tdata[3:0]);
   assign load_ok    = 32'(req_tdata[3:0]) < BLOCKS;
   assign req_amount = SIZE_BITS'(req_tdata[19:4]);
   assign free_cur   = free_valid_ff[tag_ff] ? free_rd_ff : '0;
   assign orig_cur   = orig_valid_ff[tag_ff] ? orig_rd_ff : '0;

   pfa_fit_track #(
      .IDX_W     (IDX_W),
      .SIZE_BITS (SIZE_BITS)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .ctl         (fit_ctl),
      .cand_idx    (tag_ff),
      .cand_free   (free_cur),
      .amount      (amt_ff),
      .found       (fit_found),
      .pick        (fit_pick),
      .pick_left   (fit_left),
      .pick_before (fit_before)
   );

   always_comb begin
      state_in      = state_ff;
      blocks_in     = blocks_ff;
      policy_in     = policy_ff;
      cnt_in        = cnt_ff;
      tag_in        = tag_ff;
      pend_in       = 1'b0;
      amt_in        = amt_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pick_in   = rsp_pick_ff;
      rsp_before_in = rsp_before_ff;
      orig_valid_in = orig_valid_ff;
      free_valid_in = free_valid_ff;
      orig_we       = 1'b0;
      free_we       = 1'b0;
      free_waddr    = load_addr;
      free_wdata    = req_amount;
      fit_ctl       = '{clear: 1'b0, sample: 1'b0, policy: policy_ff};

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pfa_pkg::CSR_BLOCKS_IN_USE: blocks_in = csr_data;
            pfa_pkg::CSR_FIT_POLICY:    policy_in = csr_data[1:0];
            default:                    blocks_in = blocks_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            amt_in = req_amount;
            if (req_fire) begin
               status_in = pfa_pkg::STATUS_ACK;
               unique case (req_tuser)
                  pfa_pkg::OP_RESTORE: state_in = ST_RESTORE;
                  pfa_pkg::OP_ALLOC: begin
                     fit_ctl.clear = 1'b1;
                     state_in      = ST_SCAN;
                  end
                  pfa_pkg::OP_LOAD: begin
                     orig_we = load_ok;
                     free_we = load_ok;
                     if (load_ok) begin
                        orig_valid_in[load_addr] = 1'b1;
                        free_valid_in[load_addr] = 1'b1;
                     end
                     state_in = ST_FINISH;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_RESTORE: begin
            if (issue) begin
               cnt_in  = cnt_ff + 1'b1;
               tag_in  = rd_addr;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               free_we               = 1'b1;
               free_waddr            = tag_ff;
               free_wdata            = orig_cur;
               free_valid_in[tag_ff] = 1'b1;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in  = cnt_ff + 1'b1;
               tag_in  = rd_addr;
               pend_in = 1'b1;
            end
            fit_ctl.sample = pend_ff;
            if (!issue && !pend_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (fit_found) begin
               free_we                 = 1'b1;
               free_waddr              = fit_pick;
               free_wdata              = fit_left;
               free_valid_in[fit_pick] = 1'b1;
               status_in               = pfa_pkg::STATUS_PLACED;
            end else begin
               status_in = pfa_pkg::STATUS_WAIT;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == pfa_pkg::STATUS_PLACED) begin
                  rsp_pick_in   = 4'(fit_pick);
                  rsp_before_in = 16'(fit_before);
               end else begin
                  rsp_pick_in   = '0;
                  rsp_before_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (orig_we) begin
         orig_mem[load_addr] <= req_amount;
      end
      orig_rd_ff <= orig_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      free_rd_ff <= free_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         blocks_ff     <= '0;
         policy_ff     <= pfa_pkg::POLICY_FIRST;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         orig_valid_ff <= '0;
         free_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         blocks_ff     <= blocks_in;
         policy_ff     <= policy_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         orig_valid_ff <= orig_valid_in;
         free_valid_ff <= free_valid_in;
      end
      cnt_ff        <= cnt_in;
      tag_ff        <= tag_in;
      amt_ff        <= amt_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pick_ff   <= rsp_pick_in;
      rsp_before_ff <= rsp_before_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_before_ff, rsp_pick_ff,
                        rsp_status_ff == pfa_pkg::STATUS_PLACED};

   `PFA_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_fire, state_ff != ST_IDLE)
   `PFA_ASSERT_IMPLY(a_scan_in_range, clock, reset,
      (state_ff == ST_SCAN || state_ff == ST_RESTORE) && issue, 32'(rd_addr) < BLOCKS)
   `PFA_ASSERT_IMPLY(a_pick_consistent, clock, reset, fit_found, fit_left <= fit_before)
   `PFA_ASSERT_IMPLY(a_refused_is_empty, clock, reset,
      rsp_valid_ff && rsp_status_ff != pfa_pkg::STATUS_PLACED,
      rsp_pick_ff == 4'd0 && rsp_before_ff == 16'd0)

endmodule

FILE: rtl/pfa_fit_track.sv
// keeps the candidate block chosen by the fit policy during an allocation scan
module pfa_fit_track #(
   parameter int IDX_W     = 4,
   parameter int SIZE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pfa_pkg::fit_ctl_type  ctl,
   input  logic [IDX_W-1:0]      cand_idx,
   input  logic [SIZE_BITS-1:0]  cand_free,
   input  logic [SIZE_BITS-1:0]  amount,
   output logic                  found,
   output logic [IDX_W-1:0]      pick,
   output logic [SIZE_BITS-1:0]  pick_left,
   output logic [SIZE_BITS-1:0]  pick_before
);

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;
   logic [SIZE_BITS-1:0] before_ff, before_in;
   logic                 fits;
   logic                 better;
   logic                 take;
   logic [SIZE_BITS-1:0] left;

   always_comb begin
      fits = cand_free >= amount;
      left = cand_free - amount;
      unique case (ctl.policy)
         pfa_pkg::POLICY_BEST:  better = left < left_ff;
         pfa_pkg::POLICY_WORST: better = left > left_ff;
         default:               better = 1'b0;
      endcase
      take = ctl.sample && fits && (!found_ff || better);

      found_in  = found_ff;
      pick_in   = pick_ff;
      left_in   = left_ff;
      before_in = before_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in  = 1'b1;
         pick_in   = cand_idx;
         left_in   = left;
         before_in = cand_free;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      pick_ff   <= pick_in;
      left_ff   <= left_in;
      before_ff <= before_in;
   end

   assign found       = found_ff;
   assign pick        = pick_ff;
   assign pick_left   = left_ff;
   assign pick_before = before_ff;

endmodule
